/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers; the caller provides clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LGP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LGP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/lgp_pkg.sv */
// ----------------------------------------------------------------------------
// lgp_pkg
// Widths and codes shared by the gradient palette modules.
// ----------------------------------------------------------------------------
package lgp_pkg;

	localparam int GSIZE_W  = 11;
	localparam int CCOUNT_W = 5;
	localparam int SLOT_W   = 4;
	localparam int INDEX_W  = 10;
	localparam int CHAN_W   = 8;
	localparam int RGB_W    = 3 * CHAN_W;
	localparam int STATUS_W = 2;
	localparam int PROD_W   = INDEX_W + CCOUNT_W;
	localparam int SEGQ_W   = PROD_W;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic REG_GRADIENT_SIZE = 1'b0;
	localparam logic REG_COLOR_COUNT   = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BAD_SETTING = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX   = 2'd2;

	localparam logic [GSIZE_W-1:0]  GSIZE_RESET  = 11'd256;
	localparam logic [CCOUNT_W-1:0] CCOUNT_RESET = 5'd2;

endpackage

/* src/lgp_div.sv */
// ----------------------------------------------------------------------------
// lgp_div
// Restoring divider, one quotient bit per cycle; dividend < divisor << QW.
// ----------------------------------------------------------------------------
module lgp_div #(
	parameter int DW = 11,
	parameter int QW = 15
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DW+QW-1:0] dividend,
	input  logic [DW-1:0]    divisor,
	output logic             done,
	output logic [QW-1:0]    quot,
	output logic [DW-1:0]    rem
);

	localparam int SW = DW + QW;
	localparam int CW = $clog2(QW + 1);

	logic [SW-1:0] rem_q;
	logic [SW-1:0] dsh_q;
	logic [QW-1:0] quot_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic          ge;

	assign ge = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(QW);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= cnt_q == CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend;
			dsh_q  <= SW'(divisor) << (QW - 1);
			quot_q <= '0;
		end else if (cnt_q != '0) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quot_q <= {quot_q[QW-2:0], ge};
			dsh_q  <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q[DW-1:0];

endmodule

/* src/lgp_key_mem.sv */
// ----------------------------------------------------------------------------
// lgp_key_mem
// Key color store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lgp_key_mem import lgp_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [RGB_W-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [RGB_W-1:0] rdata
);

	logic [RGB_W-1:0] mem_q [DEPTH];
	logic [RGB_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/linear_gradient_palette_unit.sv */
// ----------------------------------------------------------------------------
// linear_gradient_palette_unit
// Load: no result. Query with bad setting or index: result in the next cycle.
// Valid query: the result follows the 15-bit segment divide,
// two key reads and the 8-bit channel divides; busy holds the next request until then.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module linear_gradient_palette_unit import lgp_pkg::*; #(
	parameter int MAX_COLORS  = 16,
	parameter int MAX_ENTRIES = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                operation,
	input  logic [SLOT_W-1:0]   color_slot,
	input  logic [INDEX_W-1:0]  entry_index,
	input  logic [CHAN_W-1:0]   red_in,
	input  logic [CHAN_W-1:0]   green_in,
	input  logic [CHAN_W-1:0]   blue_in,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [GSIZE_W-1:0]  cfg_wdata,
	output logic                done,
	output logic [CHAN_W-1:0]   red_out,
	output logic [CHAN_W-1:0]   green_out,
	output logic [CHAN_W-1:0]   blue_out,
	output logic [STATUS_W-1:0] status
);

	localparam int AW  = (MAX_COLORS > 2) ? $clog2(MAX_COLORS) : 1;
	localparam int XW  = (AW > CCOUNT_W) ? AW : CCOUNT_W;
	localparam int CDW = GSIZE_W + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEG,
		ST_RD_LO,
		ST_RD_HI,
		ST_ADD,
		ST_CH
	} state_t;

	state_t state_q;

	logic [GSIZE_W-1:0]  gsize_q;
	logic [CCOUNT_W-1:0] ccount_q;

	logic [GSIZE_W-1:0]  d_q;
	logic [PROD_W-1:0]   prod_q;
	logic [CCOUNT_W-1:0] k_q;
	logic [GSIZE_W-1:0]  n_q;
	logic [RGB_W-1:0]    lo_q;
	logic [18:0]         plo_q  [3];
	logic signed [20:0]  pdel_q [3];
	logic                done_q;
	logic [CHAN_W-1:0]   red_q, green_q, blue_q;
	logic [STATUS_W-1:0] status_q;

	logic                accept, is_query, legal, idx_ok, seg_start;
	logic [CCOUNT_W-1:0] cm1;
	logic [PROD_W-1:0]   prod_c;
	logic                seg_done;
	logic [SEGQ_W-1:0]   seg_quot, k_full;
	logic [GSIZE_W-1:0]  seg_rem, n_c;
	logic                wrap;
	logic [CCOUNT_W-1:0] k_c, rd_k;
	logic [XW-1:0]       rd_kx, slot_x;
	logic                mem_we, mem_re;
	logic [RGB_W-1:0]    mem_rdata;
	logic [18:0]         plo_c  [3];
	logic signed [20:0]  pdel_c [3];
	logic [21:0]         num_c  [3];
	logic [CHAN_W-1:0]   ch_quot [3];
	logic                ch_done [3];
	logic                ch_all_done;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gsize_q  <= GSIZE_RESET;
			ccount_q <= CCOUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRADIENT_SIZE: gsize_q  <= cfg_wdata;
				REG_COLOR_COUNT:   ccount_q <= cfg_wdata[CCOUNT_W-1:0];
				default:           ;
			endcase
		end
	end

	// ---------------------------------------------------------------- request
	assign busy     = state_q != ST_IDLE;
	assign accept   = start & ~busy;
	assign is_query = operation == OP_QUERY;
	assign legal    = !(ccount_q < CCOUNT_W'(2) || 32'(ccount_q) > MAX_COLORS ||
		gsize_q < GSIZE_W'(ccount_q) || 32'(gsize_q) > MAX_ENTRIES);
	assign idx_ok    = GSIZE_W'(entry_index) < gsize_q;
	assign seg_start = accept & is_query & legal & idx_ok;
	assign cm1       = ccount_q - 1'b1;
	assign prod_c    = PROD_W'(entry_index) * PROD_W'(cm1);

	// ---------------------------------------------------------------- segment
	lgp_div #(
		.DW(GSIZE_W),
		.QW(SEGQ_W)
	) u_seg_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (seg_start),
		.dividend ((GSIZE_W + SEGQ_W)'(prod_c)),
		.divisor  (gsize_q - 1'b1),
		.done     (seg_done),
		.quot     (seg_quot),
		.rem      (seg_rem)
	);

	// exact multiple of D lands on the end of the previous segment
	assign wrap   = (seg_rem == '0) && (prod_q != '0);
	assign k_full = wrap ? seg_quot - 1'b1 : seg_quot;
	assign k_c    = k_full[CCOUNT_W-1:0];
	assign n_c    = wrap ? d_q : seg_rem;

	// ---------------------------------------------------------------- key store
	assign rd_k   = (state_q == ST_RD_LO) ? k_q + 1'b1 : k_c;
	assign rd_kx  = XW'(rd_k);
	assign slot_x = XW'(color_slot);
	assign mem_re = (state_q == ST_SEG && seg_done) || state_q == ST_RD_LO;
	assign mem_we = accept & (operation == OP_LOAD) & (32'(color_slot) < MAX_COLORS);

	// loads are taken only while idle, so no read of a query can overlap a write
	lgp_key_mem #(
		.DEPTH(MAX_COLORS),
		.AW   (AW)
	) u_key_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (slot_x[AW-1:0]),
		.wdata ({red_in, green_in, blue_in}),
		.re    (mem_re),
		.raddr (rd_kx[AW-1:0]),
		.rdata (mem_rdata)
	);

	// ---------------------------------------------------------------- channels
	always_comb begin
		logic [CHAN_W-1:0]  lo_b, hi_b;
		logic signed [8:0]  dlt;
		for (int i = 0; i < 3; i++) begin
			lo_b      = lo_q[CHAN_W*i +: CHAN_W];
			hi_b      = mem_rdata[CHAN_W*i +: CHAN_W];
			dlt       = $signed({1'b0, hi_b}) - $signed({1'b0, lo_b});
			plo_c[i]  = 19'(lo_b) * 19'(d_q);
			pdel_c[i] = 21'(dlt) * 21'($signed({1'b0, n_q}));
			num_c[i]  = {2'b0, plo_q[i], 1'b0} + {pdel_q[i], 1'b0} + 22'(d_q);
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_ch
		lgp_div #(
			.DW(CDW),
			.QW(CHAN_W)
		) u_ch_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (state_q == ST_ADD),
			.dividend (num_c[g][CDW+CHAN_W-1:0]),
			.divisor  ({d_q, 1'b0}),
			.done     (ch_done[g]),
			.quot     (ch_quot[g]),
			.rem      ()
		);
	end

	assign ch_all_done = ch_done[0] & ch_done[1] & ch_done[2];

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			done_q   <= 1'b0;
			red_q    <= '0;
			green_q  <= '0;
			blue_q   <= '0;
			status_q <= STATUS_OK;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && is_query) begin
						if (!legal || !idx_ok) begin
							done_q   <= 1'b1;
							red_q    <= '0;
							green_q  <= '0;
							blue_q   <= '0;
							status_q <= legal ? STATUS_BAD_INDEX : STATUS_BAD_SETTING;
						end else begin
							state_q <= ST_SEG;
						end
					end
				end
				ST_SEG: begin
					if (seg_done) begin
						state_q <= ST_RD_LO;
					end
				end
				ST_RD_LO: state_q <= ST_RD_HI;
				ST_RD_HI: state_q <= ST_ADD;
				ST_ADD:   state_q <= ST_CH;
				ST_CH: begin
					if (ch_all_done) begin
						state_q  <= ST_IDLE;
						done_q   <= 1'b1;
						red_q    <= ch_quot[2];
						green_q  <= ch_quot[1];
						blue_q   <= ch_quot[0];
						status_q <= STATUS_OK;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (seg_start) begin
			d_q    <= gsize_q - 1'b1;
			prod_q <= prod_c;
		end
		if (state_q == ST_SEG && seg_done) begin
			k_q <= k_c;
			n_q <= n_c;
		end
		if (state_q == ST_RD_LO) begin
			lo_q <= mem_rdata;
		end
		if (state_q == ST_RD_HI) begin
			for (int i = 0; i < 3; i++) begin
				plo_q[i]  <= plo_c[i];
				pdel_q[i] <= pdel_c[i];
			end
		end
	end

	assign done      = done_q;
	assign red_out   = red_q;
	assign green_out = green_q;
	assign blue_out  = blue_q;
	assign status    = status_q;

	// ---------------------------------------------------------------- checks
	`LGP_ASSERT_NXT(a_load_no_result, accept && operation == OP_LOAD, !done_q,
		"load produced a result")
	`LGP_ASSERT_NXT(a_bad_setting, accept && is_query && !legal,
		done_q && status_q == STATUS_BAD_SETTING, "illegal setting not reported")
	`LGP_ASSERT_IMP(a_err_black, done_q && status_q != STATUS_OK,
		red_q == '0 && green_q == '0 && blue_q == '0, "error result carries color")
	`LGP_ASSERT_IMP(a_done_idle, done_q, state_q == ST_IDLE, "result while busy")

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for linear_gradient_palette_unit. Fills every key color
// slot, then walks through gradient settings from legal extremes to illegal
// ones while loading colors and querying entries. A scoreboard predicts each
// palette entry with exact integer interpolation and checks every result.
// ----------------------------------------------------------------------------
module testbench;
	import lgp_pkg::*;

	localparam int MAX_COLORS   = 16;
	localparam int MAX_ENTRIES  = 1024;
	localparam int SETTLE_TICKS = 32;
	localparam int STALL_LIMIT  = 3000;
	localparam int LEGAL_ITEMS  = 150;
	localparam int BAD_ITEMS    = 30;

	typedef struct packed {
		logic [CHAN_W-1:0]   red;
		logic [CHAN_W-1:0]   green;
		logic [CHAN_W-1:0]   blue;
		logic [STATUS_W-1:0] status;
	} palette_entry_t;

	class palette_scoreboard;
		logic [GSIZE_W-1:0]  grad_size;
		logic [CCOUNT_W-1:0] color_cnt;
		logic [RGB_W-1:0]    key_color [MAX_COLORS];
		palette_entry_t      pending_entries [$];
		int                  mismatches;
		int                  loads;
		int                  queries;
		int                  status_seen [3];

		function new();
			grad_size  = GSIZE_RESET;
			color_cnt  = CCOUNT_RESET;
			mismatches = 0;
			loads      = 0;
			queries    = 0;
			foreach (status_seen[s]) status_seen[s] = 0;
			foreach (key_color[s]) key_color[s] = '0;
		endfunction

		function void write_register(logic idx, logic [GSIZE_W-1:0] value);
			if (idx == REG_GRADIENT_SIZE)
				grad_size = value;
			else
				color_cnt = value[CCOUNT_W-1:0];
		endfunction

		function logic [CHAN_W-1:0] blend_channel(logic [CHAN_W-1:0] lo,
			logic [CHAN_W-1:0] hi, longint n, longint d);
			longint num;
			longint q;
			num = 2 * longint'(lo) * d + 2 * (longint'(hi) - longint'(lo)) * n + d;
			if (num < 0)
				num = 0;
			q = num / (2 * d);
			if (q > 255)
				q = 255;
			return q[CHAN_W-1:0];
		endfunction

		function palette_entry_t gradient_entry(logic [INDEX_W-1:0] idx);
			palette_entry_t e;
			longint         s;
			longint         c;
			longint         d;
			longint         prod;
			longint         k;
			longint         n;
			logic [RGB_W-1:0] lo;
			logic [RGB_W-1:0] hi;
			s = grad_size;
			c = color_cnt;
			e = '0;
			if (c < 2 || c > MAX_COLORS || s < c || s > MAX_ENTRIES) begin
				e.status = STATUS_BAD_SETTING;
				return e;
			end
			if (idx >= s) begin
				e.status = STATUS_BAD_INDEX;
				return e;
			end
			d    = s - 1;
			prod = longint'(idx) * (c - 1);
			k    = (idx == 0) ? 0 : (prod + d - 1) / d - 1;
			if (k > c - 2)
				k = c - 2;
			n  = prod - k * d;
			lo = key_color[k];
			hi = key_color[k + 1];
			e.red    = blend_channel(lo[23:16], hi[23:16], n, d);
			e.green  = blend_channel(lo[15:8], hi[15:8], n, d);
			e.blue   = blend_channel(lo[7:0], hi[7:0], n, d);
			e.status = STATUS_OK;
			return e;
		endfunction

		function void note_request(logic op, logic [SLOT_W-1:0] slot,
			logic [INDEX_W-1:0] idx, logic [RGB_W-1:0] rgb);
			if (op == OP_LOAD) begin
				loads++;
				key_color[slot] = rgb;
			end else begin
				queries++;
				pending_entries.push_back(gradient_entry(idx));
			end
		endfunction

		function void check_result(palette_entry_t got);
			palette_entry_t want;
			if (pending_entries.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] unexpected entry r=%0d g=%0d b=%0d status=%0d",
						$realtime, got.red, got.green, got.blue, got.status);
				return;
			end
			want = pending_entries.pop_front();
			if (want.status <= STATUS_BAD_INDEX)
				status_seen[want.status]++;
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("[%0t] entry mismatch: expected r=%0d g=%0d b=%0d status=%0d",
						$realtime, want.red, want.green, want.blue, want.status);
					$display("[%0t]                 got r=%0d g=%0d b=%0d status=%0d",
						$realtime, got.red, got.green, got.blue, got.status);
				end
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                operation;
	logic [SLOT_W-1:0]   color_slot;
	logic [INDEX_W-1:0]  entry_index;
	logic [CHAN_W-1:0]   red_in;
	logic [CHAN_W-1:0]   green_in;
	logic [CHAN_W-1:0]   blue_in;
	logic                cfg_we;
	logic                cfg_index;
	logic [GSIZE_W-1:0]  cfg_wdata;
	logic                done;
	logic [CHAN_W-1:0]   red_out;
	logic [CHAN_W-1:0]   green_out;
	logic [CHAN_W-1:0]   blue_out;
	logic [STATUS_W-1:0] status;

	palette_scoreboard sb;
	bit                gaps_on;
	int                stall_ticks;
	int                phases;

	linear_gradient_palette_unit #(
		.MAX_COLORS (MAX_COLORS),
		.MAX_ENTRIES(MAX_ENTRIES)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.color_slot (color_slot),
		.entry_index(entry_index),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.done       (done),
		.red_out    (red_out),
		.green_out  (green_out),
		.blue_out   (blue_out),
		.status     (status)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result({red_out, green_out, blue_out, status});
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_we)
			stall_ticks = 0;
		else
			stall_ticks++;
		if (stall_ticks >= STALL_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic sender_gap();
		if (gaps_on) begin
			while ($urandom_range(99) < 37) begin
				start = 1'b0;
				if ($urandom_range(7) == 0)
					repeat ($urandom_range(36, 1)) @(negedge clk);
				else
					@(negedge clk);
			end
		end
	endtask

	task automatic issue_request(input logic op, input logic [SLOT_W-1:0] slot,
		input logic [INDEX_W-1:0] idx, input logic [RGB_W-1:0] rgb);
		sender_gap();
		operation   = op;
		color_slot  = slot;
		entry_index = idx;
		red_in      = rgb[23:16];
		green_in    = rgb[15:8];
		blue_in     = rgb[7:0];
		start       = 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_request(op, slot, idx, rgb);
		@(negedge clk);
	endtask

	task automatic load_color(input logic [SLOT_W-1:0] slot, input logic [RGB_W-1:0] rgb);
		issue_request(OP_LOAD, slot, INDEX_W'($urandom), rgb);
	endtask

	task automatic query_entry(input logic [INDEX_W-1:0] idx);
		issue_request(OP_QUERY, SLOT_W'($urandom), idx, RGB_W'($urandom));
	endtask

	// drain, let the pipeline settle, then program both registers
	task automatic set_gradient(input logic [GSIZE_W-1:0] size, input logic [CCOUNT_W-1:0] cnt);
		start = 1'b0;
		while (sb.pending_entries.size() != 0) @(negedge clk);
		repeat (SETTLE_TICKS) @(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = REG_GRADIENT_SIZE;
		cfg_wdata = size;
		@(negedge clk);
		sb.write_register(REG_GRADIENT_SIZE, size);
		cfg_index = REG_COLOR_COUNT;
		cfg_wdata = {(GSIZE_W - CCOUNT_W)'($urandom), cnt};
		@(negedge clk);
		sb.write_register(REG_COLOR_COUNT, cfg_wdata);
		cfg_we = 1'b0;
		phases++;
	endtask

	task automatic run_phase(input int size, input int cnt, input int items);
		int top;
		int pick;
		int idx;
		set_gradient(GSIZE_W'(size), CCOUNT_W'(cnt));
		top = (size > MAX_ENTRIES) ? MAX_ENTRIES - 1 : size - 1;
		for (int i = 0; i < items; i++) begin
			pick = $urandom_range(99);
			if (pick < 25) begin
				load_color(SLOT_W'($urandom), RGB_W'($urandom));
			end else begin
				pick = $urandom_range(99);
				if (pick < 70 && top >= 0)
					idx = $urandom_range(top);
				else if (pick < 82)
					case ($urandom_range(2))
						0: idx = 0;
						1: idx = (top < 0) ? 0 : top;
						default: idx = (top + 1 > MAX_ENTRIES - 1) ? MAX_ENTRIES - 1 : top + 1;
					endcase
				else
					idx = $urandom;
				query_entry(INDEX_W'(idx));
			end
		end
	endtask

	int fixed_size  [12] = '{2, 1024, 16, 3, 1000, 15, 0, 1024, 1025, 1024, 2047, 5};
	int fixed_count [12] = '{2, 16, 16, 2, 7, 16, 2, 1, 2, 17, 31, 0};

	initial begin
		int cnt;
		int size;
		bit legal;
		sb          = new();
		gaps_on     = 1'b1;
		stall_ticks = 0;
		phases      = 0;
		arst_n      = 1'b0;
		start       = 1'b0;
		operation   = OP_LOAD;
		color_slot  = '0;
		entry_index = '0;
		red_in      = '0;
		green_in    = '0;
		blue_in     = '0;
		cfg_we      = 1'b0;
		cfg_index   = REG_GRADIENT_SIZE;
		cfg_wdata   = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// fill every slot, black to white at the two ends of the default gradient
		load_color(4'd0, 24'h000000);
		load_color(4'd1, 24'hFFFFFF);
		for (int s = 2; s < MAX_COLORS; s++)
			load_color(SLOT_W'(s), {8'(s * 17), 8'(255 - s * 17), (s % 2) ? 8'hFF : 8'h00});
		query_entry(10'd0);
		query_entry(10'd1);
		query_entry(10'd128);
		query_entry(10'd255);
		query_entry(10'd256);
		query_entry(10'd1023);

		for (int p = 0; p < 12; p++) begin
			legal = fixed_count[p] >= 2 && fixed_count[p] <= MAX_COLORS &&
				fixed_size[p] >= fixed_count[p] && fixed_size[p] <= MAX_ENTRIES;
			gaps_on = (p != 1);
			run_phase(fixed_size[p], fixed_count[p], legal ? LEGAL_ITEMS : BAD_ITEMS);
		end
		gaps_on = 1'b1;
		for (int p = 0; p < 6; p++) begin
			cnt  = $urandom_range(MAX_COLORS, 2);
			size = ($urandom_range(3) == 0) ? $urandom_range(MAX_ENTRIES, cnt) :
				$urandom_range(64, cnt);
			run_phase(size, cnt, LEGAL_ITEMS);
		end

		start = 1'b0;
		while (sb.pending_entries.size() != 0) @(negedge clk);
		repeat (SETTLE_TICKS) @(negedge clk);
		if (sb.pending_entries.size() != 0)
			sb.mismatches++;

		$display("covered %0d gradient settings, %0d color loads, %0d entry queries",
			phases, sb.loads, sb.queries);
		$display("results: %0d ok, %0d bad setting, %0d bad index, %0d mismatches",
			sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.mismatches);
		if (sb.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
